/* src/pnu_pkg.sv */
package pnu_pkg;

    // Upscale factor and frame store depth.
    localparam int SCALE       = 3;
    localparam int FRAME_DEPTH = 65536;
    localparam int FRAME_AW    = $clog2(FRAME_DEPTH);

    // Palette table.
    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);
    localparam int PAL_W     = 32;

    // Field widths.
    localparam int FUNC_W  = 2;
    localparam int ADDR_W  = 16;
    localparam int VALUE_W = 32;
    localparam int COORD_W = 12;
    localparam int DIM_W   = 11;
    localparam int IDX_W   = 8;

    // Truncated fixed-point step, 16 fractional bits.
    localparam int FRAC_W = 16;
    localparam int STEP_W = FRAC_W + 1;
    localparam logic [STEP_W-1:0] STEP = STEP_W'((1 << FRAC_W) / SCALE);
    localparam int PROD_W = COORD_W + STEP_W;

    // Display extent and linear source address widths.
    localparam int DISP_W = DIM_W + $clog2(SCALE + 1);
    localparam int SRC_W  = COORD_W + DIM_W + 1;

    // Operation codes carried in the input tuser.
    localparam logic [FUNC_W-1:0] FUNC_WR_FRAME = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_PAL   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FETCH    = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 1'b1;
    localparam logic [DIM_W-1:0] RST_SRC_WIDTH  = 11'd320;
    localparam logic [DIM_W-1:0] RST_SRC_HEIGHT = 11'd200;

    // Item leaving the address pipe: frame store access ready to issue.
    typedef struct packed {
        logic               valid;
        logic [FUNC_W-1:0]  func;
        logic [SRC_W-1:0]   addr;
        logic               ok;
        logic [VALUE_W-1:0] value;
    } t_addr_beat;

    // Result beat.
    typedef struct packed {
        logic [PAL_W-1:0] color;
        logic             oor;
    } t_result;

endpackage

/* src/pnu_ram.sv */
module pnu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/pnu_addr_pipe.sv */
module pnu_addr_pipe
    import pnu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [ADDR_W-1:0]  i_addr,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [COORD_W-1:0] i_dx,
    input  logic [COORD_W-1:0] i_dy,
    input  logic [DIM_W-1:0]   i_width,
    input  logic [DIM_W-1:0]   i_height,
    output t_addr_beat         o_beat
);

    // Stage 1: captured input beat.
    logic               r_s1_valid;
    logic [FUNC_W-1:0]  r_s1_func;
    logic [ADDR_W-1:0]  r_s1_addr;
    logic [VALUE_W-1:0] r_s1_value;
    logic [COORD_W-1:0] r_s1_dx;
    logic [COORD_W-1:0] r_s1_dy;

    // Stage 2: source coordinates and display bounds.
    logic               r_s2_valid;
    logic [FUNC_W-1:0]  r_s2_func;
    logic [ADDR_W-1:0]  r_s2_addr;
    logic [VALUE_W-1:0] r_s2_value;
    logic [COORD_W-1:0] r_s2_col;
    logic [COORD_W-1:0] r_s2_row;
    logic               r_s2_inb;

    // Stage 3: linear address.
    t_addr_beat r_s3;

    logic [PROD_W-1:0] w_col_prod;
    logic [PROD_W-1:0] w_row_prod;
    logic [DISP_W-1:0] w_disp_w;
    logic [DISP_W-1:0] w_disp_h;
    logic              w_inb;
    logic [SRC_W-1:0]  w_src;
    logic [SRC_W-1:0]  w_st_addr;
    t_addr_beat        n_s3;

    always_comb begin
        w_col_prod = PROD_W'(r_s1_dx) * PROD_W'(STEP);
        w_row_prod = PROD_W'(r_s1_dy) * PROD_W'(STEP);
        w_disp_w   = DISP_W'(i_width) * DISP_W'(SCALE);
        w_disp_h   = DISP_W'(i_height) * DISP_W'(SCALE);
        w_inb      = ((DISP_W + 1)'(r_s1_dx) < (DISP_W + 1)'(w_disp_w)) &&
                     ((DISP_W + 1)'(r_s1_dy) < (DISP_W + 1)'(w_disp_h));
    end

    always_comb begin
        w_src     = SRC_W'(r_s2_row) * SRC_W'(i_width) + SRC_W'(r_s2_col);
        w_st_addr = SRC_W'(r_s2_addr);
        n_s3.valid = r_s2_valid;
        n_s3.func  = r_s2_func;
        n_s3.value = r_s2_value;
        if (r_s2_func == FUNC_FETCH) begin
            n_s3.addr = w_src;
            n_s3.ok   = r_s2_inb && (w_src < SRC_W'(FRAME_DEPTH));
        end else if (r_s2_func == FUNC_WR_FRAME) begin
            n_s3.addr = w_st_addr;
            n_s3.ok   = w_st_addr < SRC_W'(FRAME_DEPTH);
        end else begin
            n_s3.addr = w_st_addr;
            n_s3.ok   = w_st_addr < SRC_W'(PAL_DEPTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3.valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3.valid <= n_s3.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_func  <= i_func;
            r_s1_addr  <= i_addr;
            r_s1_value <= i_value;
            r_s1_dx    <= i_dx;
            r_s1_dy    <= i_dy;

            r_s2_func  <= r_s1_func;
            r_s2_addr  <= r_s1_addr;
            r_s2_value <= r_s1_value;
            r_s2_col   <= w_col_prod[FRAC_W +: COORD_W];
            r_s2_row   <= w_row_prod[FRAC_W +: COORD_W];
            r_s2_inb   <= w_inb;

            r_s3.func  <= n_s3.func;
            r_s3.addr  <= n_s3.addr;
            r_s3.ok    <= n_s3.ok;
            r_s3.value <= n_s3.value;
        end
    end

    assign o_beat = r_s3;

endmodule

/* src/pnu_out_buf.sv */
module pnu_out_buf
    import pnu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_en,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    // The pipeline moves only while the skid entry is free, so a push never
    // meets a full buffer.
    assign o_en = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !i_ready) begin
            if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && !i_ready) begin
            if (i_push) begin
                r_skid <= i_data;
            end
        end else if (r_skid_valid) begin
            r_out <= r_skid;
        end else if (i_push) begin
            r_out <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* src/palette_nearest_upscaler.sv */
// Channel   | Direction | tdata (low bit up)                          | tuser
// ----------+-----------+---------------------------------------------+-------------
// s_axis    | in        | store_address, write_value, display_x,      | func
//           |           | display_y (72 bits)                         |
// m_axis    | out       | pixel_color (32 bits)                       | out_of_range
// cfg       | in        | i_cfg_index selects source_width or height  | -
//
// One beat enters per clock unless m_axis stalls; writes produce no result. Valid
// bits and size registers reset synchronously on i_rst_n low: source size returns
// to 320 x 200 and every palette entry reads as zero until written. A stall on
// m_axis freezes the whole pipeline once the skid entry behind the output register
// fills, so nothing is lost or repeated.
module palette_nearest_upscaler
    import pnu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_wdata,

    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [15:0] store_address, [47:16] write_value, [59:48] display_x,
    // [71:60] display_y
    input  logic [71:0]          i_s_axis_tdata,
    // [1:0] func
    input  logic [FUNC_W-1:0]    i_s_axis_tuser,

    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [31:0] pixel_color
    output logic [PAL_W-1:0]     o_m_axis_tdata,
    // [0] out_of_range
    output logic                 o_m_axis_tuser
);

    // Source size. Written only while the pipeline is empty: a user rule, unenforced.
    logic [DIM_W-1:0] r_src_width;
    logic [DIM_W-1:0] r_src_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= RST_SRC_WIDTH;
            r_src_height <= RST_SRC_HEIGHT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_wdata;
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Global advance: every stage and both memory read registers move together.
    logic w_en;

    assign o_s_axis_tready = w_en;

    // Stages 1 to 3: coordinate scaling, bounds checks and the linear frame
    // address (row * width + column).
    t_addr_beat w_s3;

    pnu_addr_pipe u_addr_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_s_axis_tvalid),
        .i_func   (i_s_axis_tuser),
        .i_addr   (i_s_axis_tdata[15:0]),
        .i_value  (i_s_axis_tdata[47:16]),
        .i_dx     (i_s_axis_tdata[59:48]),
        .i_dy     (i_s_axis_tdata[71:60]),
        .i_width  (r_src_width),
        .i_height (r_src_height),
        .o_beat   (w_s3)
    );

    // Stage 4: frame store access. A frame write lands here, in order with the
    // fetches around it, so a fetch always sees every earlier write.
    logic [IDX_W-1:0] w_frame_idx;
    logic             w_frame_we;

    assign w_frame_we = w_s3.valid && (w_s3.func == FUNC_WR_FRAME) && w_s3.ok;

    pnu_ram #(
        .WIDTH (IDX_W),
        .DEPTH (FRAME_DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_we    (w_frame_we),
        .i_addr  (w_s3.addr[FRAME_AW-1:0]),
        .i_wdata (w_s3.value[IDX_W-1:0]),
        .o_rdata (w_frame_idx)
    );

    logic               r_s4_valid;
    logic [FUNC_W-1:0]  r_s4_func;
    logic               r_s4_ok;
    logic [PAL_AW-1:0]  r_s4_pidx;
    logic [VALUE_W-1:0] r_s4_value;

    // Stage 5: palette access. For a fetch the index comes from the frame
    // store read; for a palette write it comes from the store address.
    logic [PAL_AW-1:0] w_pal_addr;
    logic              w_pal_we;
    logic [PAL_W-1:0]  w_pal_rdata;

    assign w_pal_addr = (r_s4_func == FUNC_FETCH) ? PAL_AW'(w_frame_idx) : r_s4_pidx;
    assign w_pal_we   = r_s4_valid && (r_s4_func == FUNC_WR_PAL) && r_s4_ok;

    pnu_ram #(
        .WIDTH (PAL_W),
        .DEPTH (PAL_DEPTH)
    ) u_pal_ram (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_we    (w_pal_we),
        .i_addr  (w_pal_addr),
        .i_wdata (r_s4_value),
        .o_rdata (w_pal_rdata)
    );

    // One valid bit per palette entry stands in for clearing the table: an
    // entry never written since reset reads as color zero.
    logic [PAL_DEPTH-1:0] r_pal_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_vld <= '0;
        end else if (w_en && w_pal_we) begin
            r_pal_vld[w_pal_addr] <= 1'b1;
        end
    end

    logic              r_s5_valid;
    logic [FUNC_W-1:0] r_s5_func;
    logic              r_s5_inb;
    logic              r_s5_pvld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else if (w_en) begin
            r_s4_valid <= w_s3.valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_func  <= w_s3.func;
            r_s4_ok    <= w_s3.ok;
            r_s4_pidx  <= w_s3.addr[PAL_AW-1:0];
            r_s4_value <= w_s3.value;

            r_s5_func  <= r_s4_func;
            r_s5_inb   <= r_s4_ok;
            r_s5_pvld  <= r_pal_vld[w_pal_addr];
        end
    end

    // Output register with a one-entry skid behind it.
    logic    w_push;
    t_result w_result;
    t_result w_out;

    assign w_push         = w_en && r_s5_valid && (r_s5_func == FUNC_FETCH);
    assign w_result.color = (r_s5_inb && r_s5_pvld) ? w_pal_rdata : '0;
    assign w_result.oor   = !r_s5_inb;

    pnu_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .o_en    (w_en),
        .o_valid (o_m_axis_tvalid),
        .o_data  (w_out),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = w_out.color;
    assign o_m_axis_tuser = w_out.oor;

endmodule
